// ===== design/lcdns_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdns_pkg : shared types and constants of the character LCD nibble sequencer
// Request and response beat types, controller/datapath command and status,
// command codes, wait codes and the power-up init nibble table.
// ----------------------------------------------------------------------------
package lcdns_pkg;

   // request beat, fixed-width fields (the printed value travels beside it)
   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data_byte;
      logic [1:0] line;
      logic [4:0] column;
   } req_type;

   // response beat: one nibble transfer
   typedef struct packed {
      logic        reg_select;
      logic [3:0]  nibble;
      logic [13:0] pre_wait_us;
      logic [13:0] post_wait_us;
      logic        last;
   } rsp_type;

   // command codes
   localparam logic [2:0] CMD_INIT   = 3'd0;
   localparam logic [2:0] CMD_CHAR   = 3'd1;
   localparam logic [2:0] CMD_INSTR  = 3'd2;
   localparam logic [2:0] CMD_CLEAR  = 3'd3;
   localparam logic [2:0] CMD_HOME   = 3'd4;
   localparam logic [2:0] CMD_LOCATE = 3'd5;
   localparam logic [2:0] CMD_PRINT  = 3'd6;

   // byte register load sources
   localparam logic [1:0] BS_DATA   = 2'd0;
   localparam logic [1:0] BS_LOCATE = 2'd1;
   localparam logic [1:0] BS_CONST  = 2'd2;

   // nibble sources
   localparam logic [1:0] NS_CONST   = 2'd0;
   localparam logic [1:0] NS_BYTE_HI = 2'd1;
   localparam logic [1:0] NS_BYTE_LO = 2'd2;
   localparam logic [1:0] NS_DIGIT   = 2'd3;

   // wait codes
   localparam logic       PRE_NONE      = 1'b0;
   localparam logic       PRE_POWERUP   = 1'b1;
   localparam logic [1:0] POST_NORMAL   = 2'd0;
   localparam logic [1:0] POST_INIT_GAP = 2'd1;
   localparam logic [1:0] POST_CLEAR    = 2'd2;

   localparam logic [13:0] WAIT_POWERUP  = 14'd15000;
   localparam logic [13:0] WAIT_INIT_GAP = 14'd10050;
   localparam logic [13:0] WAIT_NORMAL   = 14'd50;
   localparam logic [13:0] WAIT_CLEAR    = 14'd1700;

   // instruction bytes and character nibbles
   localparam logic [7:0] BYTE_CLEAR  = 8'h01;
   localparam logic [7:0] BYTE_HOME   = 8'h02;
   localparam logic [3:0] NIB_MINUS_HI = 4'h2;
   localparam logic [3:0] NIB_MINUS_LO = 4'hD;
   localparam logic [3:0] NIB_DIGIT_HI = 4'h3;
   localparam logic [3:0] INIT_LAST_STEP = 4'd11;

   // controller -> datapath
   typedef struct packed {
      logic       byte_load;
      logic [1:0] byte_src;
      logic [7:0] const_byte;
      logic       conv_load;
      logic       conv_step;
      logic       digit_shift;
      logic       emit;
      logic [1:0] nib_src;
      logic [3:0] nib_const;
      logic       rs;
      logic       pre_code;
      logic [1:0] post_code;
      logic       last;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic neg;
      logic locate_ok;
      logic conv_last;
      logic top_zero;
      logic count_one;
   } dp_status_type;

   // power-up sequence: 3, 3, 3, 2, then 0x28, 0x0E, 0x06, 0x01 as nibble pairs
   function automatic logic [3:0] init_nibble(input logic [3:0] step);
      logic [3:0] nib;
      begin
         case (step)
            4'd0, 4'd1, 4'd2: nib = 4'h3;
            4'd3, 4'd4:       nib = 4'h2;
            4'd5:             nib = 4'h8;
            4'd6, 4'd8, 4'd10: nib = 4'h0;
            4'd7:             nib = 4'hE;
            4'd9:             nib = 4'h6;
            4'd11:            nib = 4'h1;
            default:          nib = 4'h0;
         endcase
         return nib;
      end
   endfunction

endpackage

// ===== design/char_lcd_nibble_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer : 4-bit character LCD transfer sequencer
// Turns one LCD command into the run of nibble transfers the panel needs.
// ----------------------------------------------------------------------------
// Usage:
//  - Request: drive req_data (cmd, data_byte, line, column) and req_value,
//    pulse start. The beat is taken on a clock edge with start high and busy
//    low; busy then stays high until the last nibble of the run has been
//    issued. Unused fields are ignored.
//  - Response: each nibble transfer shows on rsp_data for exactly one cycle
//    with rsp_valid high; rsp_data.last marks the final beat of the run.
//    The receiver cannot hold beats off, so it must take every strobe.
//  - Each beat is registered in the response register. Throughput: one beat
//    per cycle within a run, but a print run issues none while it converts
//    and strips zeros; the next request can be taken at the edge that ends
//    the last beat. Init: 12 beats. Char, instruction, clear, home, locate:
//    2 beats. Print integer: the minus (2 beats), VALUE_BITS bit-serial BCD
//    steps, a strip step per dropped zero, 2 beats per digit (ten at 32 bits).
//  - Locate out of range and the unused command code emit no beat; busy
//    then never rises.
//  - Reset: synchronous, active high; returns to idle and drops any run in
//    flight. No state is kept between commands.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  lcdns_pkg::req_type    req_data,
   input  logic [VALUE_BITS-1:0] req_value,
   // response channel
   output logic                  rsp_valid,
   output lcdns_pkg::rsp_type    rsp_data
);

   lcdns_pkg::dp_cmd_type    dp_cmd;
   lcdns_pkg::dp_status_type dp_status;

   // controller: per-command sequencing
   lcdns_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_data.cmd),
      .status  (dp_status),
      .dp_cmd  (dp_cmd),
      .busy    (busy)
   );

   // datapath: byte/BCD registers and the response register
   lcdns_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .req_data  (req_data),
      .req_value (req_value),
      .status    (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a new run never starts right on the heels of a last beat
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("beat directly follows last beat");

   // a beat that is not last belongs to a run still in progress
   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("non-last beat while idle");

   // no beat in the cycle after an accepted request
   a_no_beat_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_valid)
      else $error("beat right after accept");

   // power-up wait only on the first init nibble
   a_powerup_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.pre_wait_us != 14'd0) |->
         (rsp_data.nibble == 4'h3) && !rsp_data.reg_select && !rsp_data.last)
      else $error("power-up wait on wrong beat");

endmodule

// ===== design/lcdns_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcdns_ctrl : sequencing state machine
// Walks each command through its nibble run and steers the datapath.
// ----------------------------------------------------------------------------
module lcdns_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [2:0]               req_cmd,
   input  lcdns_pkg::dp_status_type status,
   output lcdns_pkg::dp_cmd_type    dp_cmd,
   output logic                     busy
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_INIT     = 4'd1;
   localparam logic [3:0] ST_BYTE_HI  = 4'd2;
   localparam logic [3:0] ST_BYTE_LO  = 4'd3;
   localparam logic [3:0] ST_MINUS_HI = 4'd4;
   localparam logic [3:0] ST_MINUS_LO = 4'd5;
   localparam logic [3:0] ST_CONV     = 4'd6;
   localparam logic [3:0] ST_STRIP    = 4'd7;
   localparam logic [3:0] ST_DIG_HI   = 4'd8;
   localparam logic [3:0] ST_DIG_LO   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       rs_ff, rs_in;
   logic [1:0] post_ff, post_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         rs_ff    <= 1'b0;
         post_ff  <= lcdns_pkg::POST_NORMAL;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         rs_ff    <= rs_in;
         post_ff  <= post_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rs_in    = rs_ff;
      post_in  = post_ff;
      dp_cmd   = '0;
      dp_cmd.pre_code  = lcdns_pkg::PRE_NONE;
      dp_cmd.post_code = lcdns_pkg::POST_NORMAL;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rs_in   = 1'b0;
               post_in = lcdns_pkg::POST_NORMAL;
               case (req_cmd)
                  lcdns_pkg::CMD_INIT: begin
                     step_in  = '0;
                     state_in = ST_INIT;
                  end
                  lcdns_pkg::CMD_CHAR, lcdns_pkg::CMD_INSTR: begin
                     dp_cmd.byte_load = 1'b1;
                     dp_cmd.byte_src  = lcdns_pkg::BS_DATA;
                     rs_in    = (req_cmd == lcdns_pkg::CMD_CHAR);
                     state_in = ST_BYTE_HI;
                  end
                  lcdns_pkg::CMD_CLEAR, lcdns_pkg::CMD_HOME: begin
                     dp_cmd.byte_load  = 1'b1;
                     dp_cmd.byte_src   = lcdns_pkg::BS_CONST;
                     dp_cmd.const_byte = (req_cmd == lcdns_pkg::CMD_CLEAR) ?
                                         lcdns_pkg::BYTE_CLEAR : lcdns_pkg::BYTE_HOME;
                     post_in  = lcdns_pkg::POST_CLEAR;
                     state_in = ST_BYTE_HI;
                  end
                  lcdns_pkg::CMD_LOCATE: begin
                     // out-of-range position: no transfer at all
                     if (status.locate_ok) begin
                        dp_cmd.byte_load = 1'b1;
                        dp_cmd.byte_src  = lcdns_pkg::BS_LOCATE;
                        state_in = ST_BYTE_HI;
                     end
                  end
                  lcdns_pkg::CMD_PRINT: begin
                     dp_cmd.conv_load = 1'b1;
                     state_in = status.neg ? ST_MINUS_HI : ST_CONV;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            dp_cmd.emit      = 1'b1;
            dp_cmd.nib_src   = lcdns_pkg::NS_CONST;
            dp_cmd.nib_const = lcdns_pkg::init_nibble(step_ff);
            dp_cmd.pre_code  = (step_ff == 4'd0) ? lcdns_pkg::PRE_POWERUP
                                                 : lcdns_pkg::PRE_NONE;
            if (step_ff == 4'd0 || step_ff == 4'd1) begin
               dp_cmd.post_code = lcdns_pkg::POST_INIT_GAP;
            end else if (step_ff == lcdns_pkg::INIT_LAST_STEP) begin
               dp_cmd.post_code = lcdns_pkg::POST_CLEAR;
            end
            dp_cmd.last = (step_ff == lcdns_pkg::INIT_LAST_STEP);
            step_in     = step_ff + 4'd1;
            if (step_ff == lcdns_pkg::INIT_LAST_STEP) begin
               state_in = ST_IDLE;
            end
         end
         ST_BYTE_HI: begin
            dp_cmd.emit    = 1'b1;
            dp_cmd.nib_src = lcdns_pkg::NS_BYTE_HI;
            dp_cmd.rs      = rs_ff;
            state_in       = ST_BYTE_LO;
         end
         ST_BYTE_LO: begin
            dp_cmd.emit      = 1'b1;
            dp_cmd.nib_src   = lcdns_pkg::NS_BYTE_LO;
            dp_cmd.rs        = rs_ff;
            dp_cmd.post_code = post_ff;
            dp_cmd.last      = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_MINUS_HI: begin
            dp_cmd.emit      = 1'b1;
            dp_cmd.nib_src   = lcdns_pkg::NS_CONST;
            dp_cmd.nib_const = lcdns_pkg::NIB_MINUS_HI;
            dp_cmd.rs        = 1'b1;
            state_in         = ST_MINUS_LO;
         end
         ST_MINUS_LO: begin
            dp_cmd.emit      = 1'b1;
            dp_cmd.nib_src   = lcdns_pkg::NS_CONST;
            dp_cmd.nib_const = lcdns_pkg::NIB_MINUS_LO;
            dp_cmd.rs        = 1'b1;
            state_in         = ST_CONV;
         end
         ST_CONV: begin
            dp_cmd.conv_step = 1'b1;
            if (status.conv_last) begin
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            // drop leading zeros, keep at least one digit
            if (status.top_zero && !status.count_one) begin
               dp_cmd.digit_shift = 1'b1;
            end else begin
               state_in = ST_DIG_HI;
            end
         end
         ST_DIG_HI: begin
            dp_cmd.emit      = 1'b1;
            dp_cmd.nib_src   = lcdns_pkg::NS_CONST;
            dp_cmd.nib_const = lcdns_pkg::NIB_DIGIT_HI;
            dp_cmd.rs        = 1'b1;
            state_in         = ST_DIG_LO;
         end
         ST_DIG_LO: begin
            dp_cmd.emit        = 1'b1;
            dp_cmd.nib_src     = lcdns_pkg::NS_DIGIT;
            dp_cmd.rs          = 1'b1;
            dp_cmd.last        = status.count_one;
            dp_cmd.digit_shift = 1'b1;
            state_in           = status.count_one ? ST_IDLE : ST_DIG_HI;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/lcdns_dp.sv =====
// ----------------------------------------------------------------------------
// lcdns_dp : nibble datapath
// Byte register, binary-to-BCD converter (one bit per cycle) and the
// registered response beat.
// ----------------------------------------------------------------------------
module lcdns_dp #(
   parameter int VALUE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lcdns_pkg::dp_cmd_type    dp_cmd,
   input  lcdns_pkg::req_type       req_data,
   input  logic [VALUE_BITS-1:0]    req_value,
   output lcdns_pkg::dp_status_type status,
   output logic                     rsp_valid,
   output lcdns_pkg::rsp_type       rsp_data
);

   // decimal digits for a magnitude of up to 2^(VALUE_BITS-1)
   localparam int NUM_DIGITS = (VALUE_BITS * 302) / 1000 + 1;
   localparam int BCD_BITS   = NUM_DIGITS * 4;
   localparam int CNT_BITS   = $clog2(NUM_DIGITS + 1);
   localparam int BIT_BITS   = $clog2(VALUE_BITS);

   logic [7:0]            byte_ff, byte_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]   bcd_adj;
   logic [CNT_BITS-1:0]   dig_cnt_ff, dig_cnt_in;
   logic [BIT_BITS-1:0]   bit_cnt_ff, bit_cnt_in;
   logic                  valid_ff;
   lcdns_pkg::rsp_type    rsp_ff, rsp_in;

   logic [VALUE_BITS-1:0] mag_load;
   logic [7:0]            locate_byte;
   logic                  line_ok, column_ok;

   assign line_ok   = (req_data.line == 2'd1) || (req_data.line == 2'd2);
   assign column_ok = (req_data.column >= 5'd1) && (req_data.column <= 5'd16);
   // 0x80 + 0x40*(line-1) + (column-1)
   assign locate_byte = {1'b1, (req_data.line == 2'd2), 2'b00,
                         4'(req_data.column - 5'd1)};

   assign mag_load = req_value[VALUE_BITS-1] ?
                     (~req_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : req_value;

   // add-3 on every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ?
                             (bcd_ff[i*4 +: 4] + 4'd3) : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      byte_in    = byte_ff;
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      dig_cnt_in = dig_cnt_ff;
      bit_cnt_in = bit_cnt_ff;
      if (dp_cmd.byte_load) begin
         case (dp_cmd.byte_src)
            lcdns_pkg::BS_DATA:   byte_in = req_data.data_byte;
            lcdns_pkg::BS_LOCATE: byte_in = locate_byte;
            default:              byte_in = dp_cmd.const_byte;
         endcase
      end
      if (dp_cmd.conv_load) begin
         mag_in     = mag_load;
         bcd_in     = '0;
         dig_cnt_in = CNT_BITS'(NUM_DIGITS);
         bit_cnt_in = BIT_BITS'(VALUE_BITS - 1);
      end else if (dp_cmd.conv_step) begin
         bcd_in     = {bcd_adj[BCD_BITS-2:0], mag_ff[VALUE_BITS-1]};
         mag_in     = {mag_ff[VALUE_BITS-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - BIT_BITS'(1);
      end else if (dp_cmd.digit_shift) begin
         bcd_in     = {bcd_ff[BCD_BITS-5:0], 4'b0000};
         dig_cnt_in = dig_cnt_ff - CNT_BITS'(1);
      end
   end

   always_comb begin
      rsp_in            = rsp_ff;
      rsp_in.reg_select = dp_cmd.rs;
      rsp_in.last       = dp_cmd.last;
      case (dp_cmd.nib_src)
         lcdns_pkg::NS_BYTE_HI: rsp_in.nibble = byte_ff[7:4];
         lcdns_pkg::NS_BYTE_LO: rsp_in.nibble = byte_ff[3:0];
         lcdns_pkg::NS_DIGIT:   rsp_in.nibble = bcd_ff[BCD_BITS-1 -: 4];
         default:               rsp_in.nibble = dp_cmd.nib_const;
      endcase
      rsp_in.pre_wait_us = (dp_cmd.pre_code == lcdns_pkg::PRE_POWERUP) ?
                           lcdns_pkg::WAIT_POWERUP : 14'd0;
      case (dp_cmd.post_code)
         lcdns_pkg::POST_INIT_GAP: rsp_in.post_wait_us = lcdns_pkg::WAIT_INIT_GAP;
         lcdns_pkg::POST_CLEAR:    rsp_in.post_wait_us = lcdns_pkg::WAIT_CLEAR;
         default:                  rsp_in.post_wait_us = lcdns_pkg::WAIT_NORMAL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= dp_cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      mag_ff     <= mag_in;
      bcd_ff     <= bcd_in;
      dig_cnt_ff <= dig_cnt_in;
      bit_cnt_ff <= bit_cnt_in;
      if (dp_cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.neg       = req_value[VALUE_BITS-1];
   assign status.locate_ok = line_ok && column_ok;
   assign status.conv_last = (bit_cnt_ff == '0);
   assign status.top_zero  = (bcd_ff[BCD_BITS-1 -: 4] == 4'd0);
   assign status.count_one = (dig_cnt_ff == CNT_BITS'(1));

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== dv/char_lcd_nibble_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_tb : self-checking bench for the LCD nibble sequencer
// Sends directed and random LCD commands through the start/busy port. For each
// accepted command it works out the nibble transfers it should cause, and it
// checks every strobed transfer against them in order.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_tb;

   localparam int VALUE_BITS = 32;

   // command code with no meaning: the block must stay silent
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   // HD44780 instruction bytes used by the power-up sequence
   localparam logic [7:0] BYTE_FUNCTION_SET = 8'h28;   // 4-bit bus, 2 lines, 5x8
   localparam logic [7:0] BYTE_DISPLAY_ON   = 8'h0E;   // display + cursor on
   localparam logic [7:0] BYTE_ENTRY_MODE   = 8'h06;   // increment, no shift
   localparam logic [3:0] NIB_WAKE          = 4'h3;    // 8-bit mode wake-up
   localparam logic [3:0] NIB_BUS_4BIT      = 4'h2;    // switch to 4-bit bus

   // cursor addressing: set-DDRAM-address opcode, second line starts at 0x40
   localparam logic [7:0] BYTE_DDRAM_ADDR   = 8'h80;
   localparam logic [7:0] LINE2_OFFSET      = 8'h40;

   // characters for decimal printing
   localparam logic [7:0] CHAR_MINUS        = 8'h2D;
   localparam logic [7:0] CHAR_ZERO         = 8'h30;

   // random commands that cause transfers; with silent and directed ones
   // about 230 commands go in
   localparam int RANDOM_ITEMS = 190;
   localparam int DRAIN_EVERY  = 50;    // sender waits for an empty pipe this often
   localparam int TAIL_CYCLES  = 64;    // > worst-case run length of the block
   localparam int MAX_PRINTED  = 40;    // cap on mismatch lines

   // -------------------------------------------------------------------------
   // Scoreboard: predicts the transfers of each accepted command and checks
   // strobed transfers against the oldest prediction.
   // -------------------------------------------------------------------------
   class lcd_transfer_scoreboard;
      lcdns_pkg::rsp_type pending_transfers[$];
      lcdns_pkg::rsp_type run[$];
      int                 mismatches;
      int                 transfers_checked;
      int                 commands_per_code[8];
      int                 silent_commands;

      function void queue_nibble(logic rs, logic [3:0] nib, logic [13:0] pre,
                                 logic [13:0] post);
         lcdns_pkg::rsp_type t;
         t.reg_select   = rs;
         t.nibble       = nib;
         t.pre_wait_us  = pre;
         t.post_wait_us = post;
         t.last         = 1'b0;
         run.push_back(t);
      endfunction

      // high nibble first; only the low nibble carries the longer post wait
      function void queue_byte(logic rs, logic [7:0] b, logic [13:0] post_lo);
         queue_nibble(rs, b[7:4], '0, lcdns_pkg::WAIT_NORMAL);
         queue_nibble(rs, b[3:0], '0, post_lo);
      endfunction

      function void queue_decimal(logic [VALUE_BITS-1:0] v);
         logic [VALUE_BITS-1:0] mag;
         logic [3:0]            digit[20];
         int                    count;
         count = 0;
         if (v[VALUE_BITS-1]) begin
            queue_byte(1'b1, CHAR_MINUS, lcdns_pkg::WAIT_NORMAL);
            mag = ~v + 1'b1;   // most negative value wraps to its own magnitude
         end else begin
            mag = v;
         end
         // do-while so that zero still prints a single '0'
         do begin
            digit[count] = 4'(mag % 10);
            mag          = mag / 10;
            count++;
         end while (mag != 0);
         for (int i = count - 1; i >= 0; i--)
            queue_byte(1'b1, CHAR_ZERO + 8'(digit[i]), lcdns_pkg::WAIT_NORMAL);
      endfunction

      function int note_command(lcdns_pkg::req_type r, logic [VALUE_BITS-1:0] v);
         run.delete();
         case (r.cmd)
            lcdns_pkg::CMD_INIT: begin
               queue_nibble(1'b0, NIB_WAKE, lcdns_pkg::WAIT_POWERUP,
                            lcdns_pkg::WAIT_INIT_GAP);
               queue_nibble(1'b0, NIB_WAKE, '0, lcdns_pkg::WAIT_INIT_GAP);
               queue_nibble(1'b0, NIB_WAKE, '0, lcdns_pkg::WAIT_NORMAL);
               queue_nibble(1'b0, NIB_BUS_4BIT, '0, lcdns_pkg::WAIT_NORMAL);
               queue_byte(1'b0, BYTE_FUNCTION_SET, lcdns_pkg::WAIT_NORMAL);
               queue_byte(1'b0, BYTE_DISPLAY_ON, lcdns_pkg::WAIT_NORMAL);
               queue_byte(1'b0, BYTE_ENTRY_MODE, lcdns_pkg::WAIT_NORMAL);
               queue_byte(1'b0, lcdns_pkg::BYTE_CLEAR, lcdns_pkg::WAIT_CLEAR);
            end
            lcdns_pkg::CMD_CHAR:
               queue_byte(1'b1, r.data_byte, lcdns_pkg::WAIT_NORMAL);
            lcdns_pkg::CMD_INSTR:
               queue_byte(1'b0, r.data_byte, lcdns_pkg::WAIT_NORMAL);
            lcdns_pkg::CMD_CLEAR:
               queue_byte(1'b0, lcdns_pkg::BYTE_CLEAR, lcdns_pkg::WAIT_CLEAR);
            lcdns_pkg::CMD_HOME:
               queue_byte(1'b0, lcdns_pkg::BYTE_HOME, lcdns_pkg::WAIT_CLEAR);
            lcdns_pkg::CMD_LOCATE: begin
               if (r.line inside {2'd1, 2'd2} && r.column >= 5'd1 && r.column <= 5'd16)
                  queue_byte(1'b0, BYTE_DDRAM_ADDR
                                   + ((r.line == 2'd2) ? LINE2_OFFSET : 8'h00)
                                   + 8'(r.column - 5'd1), lcdns_pkg::WAIT_NORMAL);
            end
            lcdns_pkg::CMD_PRINT: queue_decimal(v);
            default: ;
         endcase
         commands_per_code[r.cmd]++;
         if (run.size() == 0) begin
            silent_commands++;
         end else begin
            run[run.size() - 1].last = 1'b1;
            foreach (run[i]) pending_transfers.push_back(run[i]);
         end
         return run.size();
      endfunction

      task flag_mismatch(string msg);
         if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task compare_field(string field, logic [13:0] got, logic [13:0] want);
         if (got !== want)
            flag_mismatch($sformatf("transfer %0d %s: got %0d, expected %0d",
                                    transfers_checked, field, got, want));
      endtask

      task check_transfer(lcdns_pkg::rsp_type got);
         lcdns_pkg::rsp_type want;
         if (pending_transfers.size() == 0) begin
            flag_mismatch($sformatf("transfer with nothing expected: rs=%b nibble=%h last=%b",
                                    got.reg_select, got.nibble, got.last));
            return;
         end
         want = pending_transfers.pop_front();
         transfers_checked++;
         compare_field("reg_select", 14'(got.reg_select), 14'(want.reg_select));
         compare_field("nibble", 14'(got.nibble), 14'(want.nibble));
         compare_field("pre_wait_us", got.pre_wait_us, want.pre_wait_us);
         compare_field("post_wait_us", got.post_wait_us, want.post_wait_us);
         compare_field("last", 14'(got.last), 14'(want.last));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT and its signals; every input known from time zero
   // -------------------------------------------------------------------------
   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   lcdns_pkg::req_type    req_data  = '0;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  rsp_valid;
   lcdns_pkg::rsp_type    rsp_data;

   lcd_transfer_scoreboard scoreboard = new();

   char_lcd_nibble_sequencer #(
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Sender side. All drives are nonblocking at a rising edge; handshake
   // signals are read right after the edge, so they hold pre-edge values.
   // -------------------------------------------------------------------------

   // Present one command beat and hold it until the edge that takes it. start
   // is left high so a following beat can go out back to back.
   task automatic send_command(input lcdns_pkg::req_type r,
                               input logic [VALUE_BITS-1:0] v,
                               output int produced);
      req_data  <= r;
      req_value <= v;
      start     <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      produced = scoreboard.note_command(r, v);
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Hold off until every predicted transfer has been seen. Always advances at
   // least one edge so start is never lowered and raised in the same step.
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (scoreboard.pending_transfers.size() != 0);
   endtask

   task automatic send_directed(input logic [2:0] cmd, input logic [7:0] data,
                                input logic [1:0] line, input logic [4:0] column,
                                input logic [VALUE_BITS-1:0] v);
      lcdns_pkg::req_type r;
      int                 produced;
      r.cmd       = cmd;
      r.data_byte = data;
      r.line      = line;
      r.column    = column;
      send_command(r, v, produced);
   endtask

   // Weighted command mix. Unused fields stay fully random so every input bit
   // toggles; locate is mostly in range, print mixes magnitudes of every length.
   function automatic void make_random_command(output lcdns_pkg::req_type r,
                                               output logic [VALUE_BITS-1:0] v);
      int pick;
      r.data_byte = 8'($urandom);
      r.line      = 2'($urandom);
      r.column    = 5'($urandom);
      v           = $urandom;
      pick        = $urandom_range(0, 99);
      if (pick < 32)      r.cmd = lcdns_pkg::CMD_PRINT;
      else if (pick < 52) r.cmd = lcdns_pkg::CMD_LOCATE;
      else if (pick < 66) r.cmd = lcdns_pkg::CMD_CHAR;
      else if (pick < 76) r.cmd = lcdns_pkg::CMD_INSTR;
      else if (pick < 83) r.cmd = lcdns_pkg::CMD_INIT;
      else if (pick < 89) r.cmd = lcdns_pkg::CMD_CLEAR;
      else if (pick < 95) r.cmd = lcdns_pkg::CMD_HOME;
      else                r.cmd = CMD_UNUSED;
      if (r.cmd == lcdns_pkg::CMD_LOCATE && $urandom_range(0, 4) != 0) begin
         r.line   = 2'($urandom_range(1, 2));
         r.column = 5'($urandom_range(1, 16));
      end
      if (r.cmd == lcdns_pkg::CMD_PRINT) begin
         case ($urandom_range(0, 3))
            0: ;                                            // full range as drawn
            1: v = $urandom >> $urandom_range(0, 31);      // any digit count, positive
            2: v = -($urandom >> $urandom_range(0, 31));   // same, negative
            default: begin
               case ($urandom_range(0, 3))
                  0:       v = '0;
                  1:       v = {1'b1, {(VALUE_BITS-1){1'b0}}};
                  2:       v = {1'b0, {(VALUE_BITS-1){1'b1}}};
                  default: v = '1;
               endcase
            end
         endcase
      end
   endfunction

   initial begin : stimulus
      lcdns_pkg::req_type    r;
      logic [VALUE_BITS-1:0] v;
      int                    produced;
      int                    loaded;
      int                    burst_left;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: every command, locate and print corner cases, back to back
      send_directed(lcdns_pkg::CMD_INIT,   8'h00, 2'd0, 5'd0,  '0);
      send_directed(lcdns_pkg::CMD_CHAR,   8'h00, 2'd3, 5'd31, '1);
      send_directed(lcdns_pkg::CMD_CHAR,   8'hFF, 2'd0, 5'd0,  '0);
      send_directed(lcdns_pkg::CMD_INSTR,  8'hA5, 2'd1, 5'd1,  '0);
      send_directed(lcdns_pkg::CMD_CLEAR,  8'hFF, 2'd2, 5'd16, '1);
      send_directed(lcdns_pkg::CMD_HOME,   8'h00, 2'd0, 5'd0,  '0);
      send_directed(lcdns_pkg::CMD_LOCATE, 8'h00, 2'd1, 5'd1,  '0);
      send_directed(lcdns_pkg::CMD_LOCATE, 8'hFF, 2'd2, 5'd16, '1);
      send_directed(lcdns_pkg::CMD_LOCATE, 8'h00, 2'd1, 5'd16, '0);
      // out-of-range locates: bad line, column zero, column past the panel
      send_directed(lcdns_pkg::CMD_LOCATE, 8'h00, 2'd0, 5'd1,  '0);
      send_directed(lcdns_pkg::CMD_LOCATE, 8'h00, 2'd3, 5'd8,  '0);
      send_directed(lcdns_pkg::CMD_LOCATE, 8'h00, 2'd2, 5'd0,  '0);
      send_directed(lcdns_pkg::CMD_LOCATE, 8'h00, 2'd1, 5'd17, '0);
      send_directed(lcdns_pkg::CMD_LOCATE, 8'h00, 2'd2, 5'd31, '0);
      // print: zero, minus one, both ends of the range, ten digits, negative
      send_directed(lcdns_pkg::CMD_PRINT,  8'h00, 2'd0, 5'd0,  '0);
      send_directed(lcdns_pkg::CMD_PRINT,  8'h00, 2'd0, 5'd0,  '1);
      send_directed(lcdns_pkg::CMD_PRINT,  8'h00, 2'd0, 5'd0,  32'h7FFF_FFFF);
      send_directed(lcdns_pkg::CMD_PRINT,  8'h00, 2'd0, 5'd0,  32'h8000_0000);
      send_directed(lcdns_pkg::CMD_PRINT,  8'h00, 2'd0, 5'd0,  32'd1_000_000_000);
      send_directed(lcdns_pkg::CMD_PRINT,  8'h00, 2'd0, 5'd0,  -32'sd100);
      send_directed(CMD_UNUSED,            8'hFF, 2'd3, 5'd31, '1);
      send_directed(lcdns_pkg::CMD_INIT,   8'hFF, 2'd3, 5'd31, '1);
      wait_for_drain();

      // random: bursts of back-to-back beats, random gaps between bursts
      loaded     = 0;
      burst_left = $urandom_range(1, 12);
      while (loaded < RANDOM_ITEMS) begin
         make_random_command(r, v);
         send_command(r, v, produced);
         if (produced > 0) loaded++;
         if (produced > 0 && loaded % DRAIN_EVERY == 0) begin
            wait_for_drain();
         end else if (--burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60));
         end
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d commands: init %0d, char %0d, instr %0d, clear %0d, home %0d,",
               scoreboard.commands_per_code.sum(),
               scoreboard.commands_per_code[lcdns_pkg::CMD_INIT],
               scoreboard.commands_per_code[lcdns_pkg::CMD_CHAR],
               scoreboard.commands_per_code[lcdns_pkg::CMD_INSTR],
               scoreboard.commands_per_code[lcdns_pkg::CMD_CLEAR],
               scoreboard.commands_per_code[lcdns_pkg::CMD_HOME]);
      $display("locate %0d, print %0d, unused %0d; %0d silent, %0d transfers checked",
               scoreboard.commands_per_code[lcdns_pkg::CMD_LOCATE],
               scoreboard.commands_per_code[lcdns_pkg::CMD_PRINT],
               scoreboard.commands_per_code[CMD_UNUSED], scoreboard.silent_commands,
               scoreboard.transfers_checked);
      if (scoreboard.mismatches == 0 && scoreboard.pending_transfers.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver side: every strobed transfer is taken and checked at the edge
   // that ends its cycle.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1)
            scoreboard.check_transfer(rsp_data);
         else if (rsp_valid !== 1'b0)
            scoreboard.flag_mismatch("response strobe is unknown");
      end
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #2ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== char_lcd_nibble_sequencer.f =====
design/lcdns_pkg.sv
design/lcdns_ctrl.sv
design/lcdns_dp.sv
design/char_lcd_nibble_sequencer.sv
dv/char_lcd_nibble_sequencer_tb.sv
